FILE: sv/cle_pkg.sv
// ----------------------------------------------------------------------------
// Console line editor package
// Shared constants: key codes, printable range, capacity and reset defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cle_pkg;

  localparam int unsigned LineCapacityDef = 64;

  localparam int unsigned ModeW = 3;
  localparam int unsigned KeyW  = 8;
  localparam int unsigned FldW  = 7;

  localparam logic [ModeW-1:0] ModeChar  = 3'd0;
  localparam logic [ModeW-1:0] ModeLeft  = 3'd1;
  localparam logic [ModeW-1:0] ModeRight = 3'd2;
  localparam logic [ModeW-1:0] ModeBack  = 3'd3;
  localparam logic [ModeW-1:0] ModeDel   = 3'd4;
  localparam logic [ModeW-1:0] ModeEnter = 3'd5;

  localparam logic [KeyW-1:0] CharLow  = 8'h20;
  localparam logic [KeyW-1:0] CharHigh = 8'h7e;

  localparam logic [FldW-1:0] MaxCursorRst = 7'd63;

endpackage

`default_nettype wire

FILE: sv/console_line_editor.sv
// ----------------------------------------------------------------------------
// Console line editor
// Key-driven line buffer with cursor; emits the line character by character
// on enter.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; busy then stays
// high until the event is done. All work goes through one line memory with a
// single write port and a registered read port. Cursor moves, refused
// insertions and unknown modes go straight to the status result. An insertion
// shifts the characters from the cursor to the end up by one, a backspace or
// delete shifts those after the removed position down by one, and enter emits
// the line one character per result (an empty line gives one marker result).
// Each result shows for one cycle on res_valid_o and cannot be held off. The
// last result's strobe may overlap the next accepted transaction.
`timescale 1ns / 1ps
`default_nettype none

module console_line_editor #(
  parameter int unsigned LINE_CAPACITY = cle_pkg::LineCapacityDef
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic [cle_pkg::ModeW-1:0] mode_i,
  input  wire logic [cle_pkg::KeyW-1:0]  key_char_i,
  input  wire logic                      cfg_we_i,
  input  wire logic [cle_pkg::FldW-1:0]  cfg_wdata_i,
  output logic                           res_valid_o,
  output logic [cle_pkg::FldW-1:0]       cursor_o,
  output logic [cle_pkg::FldW-1:0]       length_o,
  output logic [cle_pkg::FldW-1:0]       char_out_o,
  output logic                           char_valid_o,
  output logic                           line_done_o,
  output logic                           last_o
);
  import cle_pkg::*;

  localparam int unsigned AW = $clog2(LINE_CAPACITY);
  localparam int unsigned CW = $clog2(LINE_CAPACITY + 1);
  localparam logic [CW-1:0] CapCnt = CW'(LINE_CAPACITY);

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_WR,
    S_DEL_RD,
    S_DEL_WR,
    S_OUT_RD,
    S_OUT_EMIT,
    S_STATUS
  } state_e;

  state_e          state_q;
  logic [CW-1:0]   cur_q;
  logic [CW-1:0]   len_q;
  logic [AW-1:0]   ptr_q;
  logic [FldW-1:0] key_q;
  logic [FldW-1:0] max_cursor_q;
  logic            marker_q;

  logic [FldW-1:0] mem_q [LINE_CAPACITY];
  logic [FldW-1:0] rdata_q;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [AW-1:0]   mem_ra;
  logic [FldW-1:0] mem_wd;

  logic            key_ok;
  logic            ins_done;
  logic            del_done;
  logic            out_last;

  assign busy     = (state_q != S_IDLE);
  assign key_ok   = (key_char_i >= CharLow) && (key_char_i <= CharHigh);
  assign ins_done = (CW'(ptr_q) == cur_q);
  assign del_done = ((CW'(ptr_q) + CW'(1)) >= len_q);
  assign out_last = ((CW'(ptr_q) + CW'(1)) == len_q);

  // memory port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_q;
    mem_wd = rdata_q;
    mem_ra = ptr_q;
    unique case (state_q)
      S_INS_RD: begin
        mem_ra = ptr_q - AW'(1);
        if (ins_done) begin
          mem_we = 1'b1;
          mem_wd = key_q;
        end
      end
      S_INS_WR: mem_we = 1'b1;
      S_DEL_RD: mem_ra = ptr_q + AW'(1);
      S_DEL_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    rdata_q <= mem_q[mem_ra];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cur_q        <= '0;
      len_q        <= '0;
      ptr_q        <= '0;
      key_q        <= '0;
      marker_q     <= 1'b0;
      max_cursor_q <= MaxCursorRst;
      res_valid_o  <= 1'b0;
      cursor_o     <= '0;
      length_o     <= '0;
      char_out_o   <= '0;
      char_valid_o <= 1'b0;
      line_done_o  <= 1'b0;
      last_o       <= 1'b0;
    end else begin
      res_valid_o <= 1'b0;
      if (cfg_we_i) begin
        max_cursor_q <= cfg_wdata_i;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            key_q    <= key_char_i[FldW-1:0];
            marker_q <= 1'b0;
            state_q  <= S_STATUS;
            unique case (mode_i)
              ModeChar: begin
                if (key_ok && (FldW'(cur_q) <= max_cursor_q) && (len_q < CapCnt)) begin
                  ptr_q   <= len_q[AW-1:0];
                  state_q <= S_INS_RD;
                end
              end
              ModeLeft: begin
                if (cur_q != '0) cur_q <= cur_q - CW'(1);
              end
              ModeRight: begin
                if (cur_q < len_q) cur_q <= cur_q + CW'(1);
              end
              ModeBack: begin
                if (cur_q != '0) begin
                  cur_q   <= cur_q - CW'(1);
                  ptr_q   <= AW'(cur_q - CW'(1));
                  state_q <= S_DEL_RD;
                end
              end
              ModeDel: begin
                if (cur_q < len_q) begin
                  ptr_q   <= AW'(cur_q);
                  state_q <= S_DEL_RD;
                end
              end
              ModeEnter: begin
                ptr_q <= '0;
                if (len_q == '0) begin
                  marker_q <= 1'b1;
                end else begin
                  state_q <= S_OUT_RD;
                end
              end
              default: ;
            endcase
          end
        end
        S_INS_RD: begin
          if (ins_done) begin
            cur_q   <= cur_q + CW'(1);
            len_q   <= len_q + CW'(1);
            state_q <= S_STATUS;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          ptr_q   <= ptr_q - AW'(1);
          state_q <= S_INS_RD;
        end
        S_DEL_RD: begin
          if (del_done) begin
            len_q   <= len_q - CW'(1);
            state_q <= S_STATUS;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          ptr_q   <= ptr_q + AW'(1);
          state_q <= S_DEL_RD;
        end
        S_OUT_RD: state_q <= S_OUT_EMIT;
        S_OUT_EMIT: begin
          res_valid_o  <= 1'b1;
          cursor_o     <= '0;
          length_o     <= '0;
          char_out_o   <= rdata_q;
          char_valid_o <= 1'b1;
          line_done_o  <= 1'b1;
          last_o       <= out_last;
          if (out_last) begin
            cur_q   <= '0;
            len_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            ptr_q   <= ptr_q + AW'(1);
            state_q <= S_OUT_RD;
          end
        end
        S_STATUS: begin
          // plain status, or the empty-line marker on enter
          res_valid_o  <= 1'b1;
          cursor_o     <= FldW'(cur_q);
          length_o     <= FldW'(len_q);
          char_out_o   <= '0;
          char_valid_o <= 1'b0;
          line_done_o  <= marker_q;
          last_o       <= 1'b1;
          state_q      <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  a_cur_within_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_q <= len_q) else $error("cursor beyond line length");

  a_len_within_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= CapCnt) else $error("line length beyond capacity");

  a_status_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !line_done_o |-> last_o && !char_valid_o)
    else $error("status result not final");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy) else $error("accepted transaction did not raise busy");

endmodule

`default_nettype wire

FILE: test/line_edit_checker.sv
// ----------------------------------------------------------------------------
// Line editor checker
// Watches the key and result channels of the console line editor. It keeps
// its own copy of the line, cursor and column limit, computes the results
// each accepted key event should give, and compares the results field by
// field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module line_edit_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      busy_i,
  input  logic [cle_pkg::ModeW-1:0] mode_i,
  input  logic [cle_pkg::KeyW-1:0]  key_char_i,
  input  logic                      cfg_we_i,
  input  logic [cle_pkg::FldW-1:0]  cfg_wdata_i,
  input  logic                      res_valid_i,
  input  logic [cle_pkg::FldW-1:0]  cursor_i,
  input  logic [cle_pkg::FldW-1:0]  length_i,
  input  logic [cle_pkg::FldW-1:0]  char_out_i,
  input  logic                      char_valid_i,
  input  logic                      line_done_i,
  input  logic                      last_i,
  output int                        errors_o,
  output int                        pending_o
);
  import cle_pkg::*;

  typedef struct packed {
    logic [FldW-1:0] cursor;
    logic [FldW-1:0] length;
    logic [FldW-1:0] char_out;
    logic            char_valid;
    logic            line_done;
    logic            last;
  } edit_result_t;

  edit_result_t    line_results_q[$];
  logic [FldW-1:0] text_mem [LineCapacityDef];
  int unsigned     caret;
  int unsigned     text_len;
  logic [FldW-1:0] max_caret;
  int              mismatch_cnt = 0;

  assign errors_o = mismatch_cnt;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_cnt++;
  endtask

  task automatic compare_field(input string name, input logic [FldW-1:0] got,
                               input logic [FldW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  task automatic check_result();
    edit_result_t want;
    if (line_results_q.size() == 0) begin
      report_mismatch("result strobe with no transaction outstanding");
      return;
    end
    want = line_results_q.pop_front();
    compare_field("cursor", cursor_i, want.cursor);
    compare_field("length", length_i, want.length);
    compare_field("char_out", char_out_i, want.char_out);
    compare_field("char_valid", FldW'(char_valid_i), FldW'(want.char_valid));
    compare_field("line_done", FldW'(line_done_i), FldW'(want.line_done));
    compare_field("last", FldW'(last_i), FldW'(want.last));
  endtask

  // close the gap left by removing the character at pos
  task automatic remove_char(input int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < text_len; i++) text_mem[i] = text_mem[i + 1];
    text_len--;
  endtask

  task automatic edit_line(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key);
    int unsigned  i;
    edit_result_t r;
    if (mode == ModeEnter) begin
      if (text_len == 0) begin
        r = '{cursor: '0, length: '0, char_out: '0, char_valid: 1'b0,
              line_done: 1'b1, last: 1'b1};
        line_results_q.push_back(r);
      end else begin
        for (i = 0; i < text_len; i++) begin
          r = '{cursor: '0, length: '0, char_out: text_mem[i], char_valid: 1'b1,
                line_done: 1'b1, last: (i + 1 == text_len)};
          line_results_q.push_back(r);
        end
      end
      caret    = 0;
      text_len = 0;
      return;
    end
    case (mode)
      ModeChar: begin
        if (key >= CharLow && key <= CharHigh && caret <= max_caret &&
            text_len < LineCapacityDef) begin
          for (i = text_len; i > caret; i--) text_mem[i] = text_mem[i - 1];
          text_mem[caret] = key[FldW-1:0];
          text_len++;
          caret++;
        end
      end
      ModeLeft: begin
        if (caret > 0) caret--;
      end
      ModeRight: begin
        if (caret < text_len) caret++;
      end
      ModeBack: begin
        if (caret > 0) begin
          caret--;
          remove_char(caret);
        end
      end
      ModeDel: begin
        if (caret < text_len) remove_char(caret);
      end
      default: ;
    endcase
    r = '{cursor: FldW'(caret), length: FldW'(text_len), char_out: '0,
          char_valid: 1'b0, line_done: 1'b0, last: 1'b1};
    line_results_q.push_back(r);
  endtask

  // results are checked before the new transaction is predicted, so a result
  // overlapping the next accepted key still pairs with the older expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      caret     = 0;
      text_len  = 0;
      max_caret = MaxCursorRst;
      line_results_q.delete();
      pending_o <= 0;
    end else begin
      if (res_valid_i) check_result();
      if (cfg_we_i) max_caret = cfg_wdata_i;
      if (start_i && !busy_i) edit_line(mode_i, key_char_i);
      pending_o <= line_results_q.size();
    end
  end

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// Console line editor testbench
// Drives directed and random key events with random gaps, changes the column
// limit between phases while the editor is idle, and reports the verdict from
// the checker's mismatch and outstanding counts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cle_pkg::*;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic [ModeW-1:0] mode_i      = '0;
  logic [KeyW-1:0]  key_char_i  = '0;
  logic             cfg_we_i    = 1'b0;
  logic [FldW-1:0]  cfg_wdata_i = '0;
  logic             busy;
  logic             res_valid_o;
  logic [FldW-1:0]  cursor_o;
  logic [FldW-1:0]  length_o;
  logic [FldW-1:0]  char_out_o;
  logic             char_valid_o;
  logic             line_done_o;
  logic             last_o;
  int               mismatches;
  int               outstanding;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  console_line_editor dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_char_i   (key_char_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_o  (res_valid_o),
    .cursor_o     (cursor_o),
    .length_o     (length_o),
    .char_out_o   (char_out_o),
    .char_valid_o (char_valid_o),
    .line_done_o  (line_done_o),
    .last_o       (last_o)
  );

  line_edit_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_i       (busy),
    .mode_i       (mode_i),
    .key_char_i   (key_char_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_valid_i  (res_valid_o),
    .cursor_i     (cursor_o),
    .length_i     (length_o),
    .char_out_i   (char_out_o),
    .char_valid_i (char_valid_o),
    .line_done_i  (line_done_o),
    .last_i       (last_o),
    .errors_o     (mismatches),
    .pending_o    (outstanding)
  );

  // mostly back to back, some short gaps, a few long ones
  task automatic idle_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (n > 0) begin
      start      <= 1'b0;
      mode_i     <= ModeW'($urandom);
      key_char_i <= KeyW'($urandom);
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic send_key(input logic [ModeW-1:0] mode, input logic [KeyW-1:0] key);
    start      <= 1'b1;
    mode_i     <= mode;
    key_char_i <= key;
    do @(posedge clk_i); while (busy);
    idle_gap();
  endtask

  // hold off until every expected result is in and the editor is idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0 || busy) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [FldW-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg_wdata_i <= FldW'($urandom);
  endtask

  function automatic logic [KeyW-1:0] pick_char();
    if ($urandom_range(0, 99) < 85) return KeyW'($urandom_range(CharLow, CharHigh));
    return KeyW'($urandom_range(0, 255));
  endfunction

  task automatic random_keys(input int count, input int enter_pct);
    int r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if ($urandom_range(0, 99) < 2) drain();
      if (r < 3) begin
        send_key(ModeW'($urandom_range(6, 7)), KeyW'($urandom));
      end else if (r < 3 + enter_pct) begin
        send_key(ModeEnter, KeyW'($urandom));
      end else begin
        r = $urandom_range(0, 94);
        if (r < 55) send_key(ModeChar, pick_char());
        else if (r < 65) send_key(ModeLeft, KeyW'($urandom));
        else if (r < 75) send_key(ModeRight, KeyW'($urandom));
        else if (r < 85) send_key(ModeBack, KeyW'($urandom));
        else send_key(ModeDel, KeyW'($urandom));
      end
    end
  endtask

  // type past capacity, poke at the full line, then flush it
  task automatic fill_line(input int count);
    repeat (count) send_key(ModeChar, KeyW'($urandom_range(CharLow, CharHigh)));
    send_key(ModeLeft, KeyW'($urandom));
    send_key(ModeChar, CharLow);
    send_key(ModeRight, KeyW'($urandom));
    send_key(ModeEnter, KeyW'($urandom));
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // edge cases at the reset column limit
    send_key(ModeEnter, 8'h00);
    send_key(ModeLeft, 8'hff);
    send_key(ModeBack, 8'h00);
    send_key(ModeDel, 8'h00);
    send_key(ModeRight, 8'h00);
    send_key(ModeChar, 8'h1f);
    send_key(ModeChar, 8'h7f);
    send_key(ModeChar, 8'hff);
    send_key(ModeChar, 8'ha0);
    send_key(ModeChar, CharLow);
    send_key(ModeChar, CharHigh);
    send_key(ModeChar, 8'h41);
    send_key(ModeLeft, 8'h00);
    send_key(ModeLeft, 8'h00);
    send_key(ModeChar, 8'h42);
    send_key(ModeDel, 8'h00);
    send_key(ModeBack, 8'h00);
    send_key(ModeRight, 8'h00);
    send_key(ModeRight, 8'h00);
    send_key(ModeDel, 8'h00);
    send_key(3'd6, 8'h55);
    send_key(3'd7, 8'haa);
    send_key(ModeEnter, 8'h00);
    send_key(ModeEnter, 8'h00);

    drain();
    write_limit(7'd0);
    random_keys(50, 8);

    drain();
    write_limit(7'd64);
    fill_line(70);
    random_keys(50, 5);

    drain();
    write_limit(7'd1);
    random_keys(50, 8);

    drain();
    write_limit(7'd127);
    random_keys(50, 4);

    drain();
    write_limit(MaxCursorRst);
    fill_line(66);
    random_keys(40, 6);

    drain();
    write_limit(FldW'($urandom_range(1, 64)));
    random_keys(60, 6);

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: sim.f
sv/cle_pkg.sv
sv/console_line_editor.sv
test/line_edit_checker.sv
test/tb_top.sv
